// ----- hw/rtl/dfm_pkg.sv -----
// dfm_pkg: shared types, sizes and frame constants for the dmx fixture mapper framer
`default_nettype none
package dfm_pkg;

  // universe and frame geometry
  localparam int UNIVERSE_SIZE = 512;
  localparam int SLOT_W        = $clog2(UNIVERSE_SIZE);
  localparam int HEAD_LEN      = 5;
  localparam int FRAME_LEN     = HEAD_LEN + UNIVERSE_SIZE + 1;
  localparam int POS_W         = $clog2(FRAME_LEN);
  localparam int SUM_W         = 11;
  localparam int NUM_CH        = 6;
  localparam int CH_W          = 3;

  // label-6 frame bytes
  localparam logic [7:0]  SOM_BYTE   = 8'h7E;
  localparam logic [7:0]  LABEL_BYTE = 8'h06;
  localparam logic [7:0]  START_CODE = 8'h00;
  localparam logic [7:0]  EOM_BYTE   = 8'hE7;
  localparam logic [15:0] DATA_LEN   = 16'(UNIVERSE_SIZE + 1);

  // command codes of an input word
  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // channel indexes in write order
  localparam logic [CH_W-1:0] CH_BRI   = 3'd0;
  localparam logic [CH_W-1:0] CH_RED   = 3'd1;
  localparam logic [CH_W-1:0] CH_GREEN = 3'd2;
  localparam logic [CH_W-1:0] CH_BLUE  = 3'd3;
  localparam logic [CH_W-1:0] CH_WHITE = 3'd4;
  localparam logic [CH_W-1:0] CH_W2    = 3'd5;

  typedef struct packed {
    logic        cmd;
    logic [9:0]  base_address;
    logic [7:0]  brightness;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  white;
    logic [7:0]  white_two;
    logic [29:0] slot_map;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_FLUSH,
    ST_TICK_RD,
    ST_TICK_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic            load;
    logic            clear;
    logic            calc;
    logic [CH_W-1:0] ch;
    logic            rd;
    logic            emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

  // header byte at a frame position below HEAD_LEN
  function automatic logic [7:0] head_byte(input logic [POS_W-1:0] pos);
    logic [7:0] b;
    b = START_CODE;
    if (pos == POS_W'(0)) b = SOM_BYTE;
    else if (pos == POS_W'(1)) b = LABEL_BYTE;
    else if (pos == POS_W'(2)) b = DATA_LEN[7:0];
    else if (pos == POS_W'(3)) b = DATA_LEN[15:8];
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dfm_ctrl.sv -----
// dfm_ctrl: controller state machine sequencing clear, set and tick work
`default_nettype none
module dfm_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    in_cmd,
  input  wire dfm_pkg::dp_stat_t       stat,
  output logic                         busy,
  output dfm_pkg::dp_cmd_t             cmd
);

  dfm_pkg::state_t               state_r, state_nxt;
  logic [dfm_pkg::CH_W-1:0]      ch_r, ch_nxt;

  // state and channel registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfm_pkg::ST_CLEAR;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    case (state_r)
      dfm_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_nxt = dfm_pkg::ST_IDLE;
      end
      dfm_pkg::ST_IDLE: begin
        ch_nxt = '0;
        if (start) begin
          if (in_cmd == dfm_pkg::CMD_TICK) state_nxt = dfm_pkg::ST_TICK_RD;
          else state_nxt = dfm_pkg::ST_SET;
        end
      end
      dfm_pkg::ST_SET: begin
        ch_nxt = ch_r + 1'b1;
        if (ch_r == dfm_pkg::CH_W2) state_nxt = dfm_pkg::ST_FLUSH;
      end
      dfm_pkg::ST_FLUSH:    state_nxt = dfm_pkg::ST_IDLE;
      dfm_pkg::ST_TICK_RD:  state_nxt = dfm_pkg::ST_TICK_OUT;
      dfm_pkg::ST_TICK_OUT: state_nxt = dfm_pkg::ST_IDLE;
      default:              state_nxt = dfm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = 1'b1;
    cmd       = '0;
    cmd.ch    = ch_r;
    case (state_r)
      dfm_pkg::ST_CLEAR:    cmd.clear = 1'b1;
      dfm_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      dfm_pkg::ST_SET:      cmd.calc = 1'b1;
      dfm_pkg::ST_FLUSH:    cmd.calc = 1'b0;
      dfm_pkg::ST_TICK_RD:  cmd.rd   = 1'b1;
      dfm_pkg::ST_TICK_OUT: cmd.emit = 1'b1;
      default:              busy     = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dfm_datapath.sv -----
// dfm_datapath: universe memory, clearing sweep, channel scaling and frame counter
`default_nettype none
module dfm_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dfm_pkg::in_word_t       in_data,
  input  wire dfm_pkg::dp_cmd_t        cmd,
  output dfm_pkg::dp_stat_t            stat,
  output logic                         out_valid,
  output dfm_pkg::out_word_t           out_data
);

  logic [7:0]                   mem [dfm_pkg::UNIVERSE_SIZE];
  dfm_pkg::in_word_t            item_r;
  logic [dfm_pkg::SLOT_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic                         wr_en_r, wr_en_nxt;
  logic [dfm_pkg::SLOT_W-1:0]   wr_addr_r;
  logic [7:0]                   wr_data_r, wr_data_nxt;
  logic [dfm_pkg::SLOT_W-1:0]   wr_addr_nxt;
  logic [7:0]                   rd_data_r;
  logic [dfm_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [dfm_pkg::POS_W-1:0]    rd_pos;
  logic [4:0]                   off;
  logic [7:0]                   colour;
  logic [15:0]                  prod;
  logic [16:0]                  quot_sum;
  logic [dfm_pkg::SUM_W-1:0]    slot_sum;
  logic [dfm_pkg::SUM_W-1:0]    slot_idx;
  logic                         slot_ok;
  logic                         is_last;

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
  end

  // clearing sweep address
  assign stat.clear_last = (clr_addr_r == dfm_pkg::SLOT_W'(dfm_pkg::UNIVERSE_SIZE - 1));
  assign clr_addr_nxt    = stat.clear_last ? '0 : clr_addr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clear) clr_addr_r <= clr_addr_nxt;
  end

  // channel offset and raw value for this step
  always_comb begin
    off    = item_r.slot_map[4:0];
    colour = item_r.brightness;
    case (cmd.ch)
      dfm_pkg::CH_BRI: begin
        off    = item_r.slot_map[4:0];
        colour = item_r.brightness;
      end
      dfm_pkg::CH_RED: begin
        off    = item_r.slot_map[9:5];
        colour = item_r.red;
      end
      dfm_pkg::CH_GREEN: begin
        off    = item_r.slot_map[14:10];
        colour = item_r.green;
      end
      dfm_pkg::CH_BLUE: begin
        off    = item_r.slot_map[19:15];
        colour = item_r.blue;
      end
      dfm_pkg::CH_WHITE: begin
        off    = item_r.slot_map[24:20];
        colour = item_r.white;
      end
      dfm_pkg::CH_W2: begin
        off    = item_r.slot_map[29:25];
        colour = item_r.white_two;
      end
      default: begin
        off    = '0;
        colour = '0;
      end
    endcase
  end

  // colour times brightness over 255, exact for 16-bit products
  assign prod     = colour * item_r.brightness;
  assign quot_sum = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};

  always_comb begin
    if (cmd.ch == dfm_pkg::CH_BRI || item_r.slot_map[4:0] != 5'd0) wr_data_nxt = colour;
    else wr_data_nxt = quot_sum[15:8];
  end

  // target slot and range check
  assign slot_sum    = {1'b0, item_r.base_address} + dfm_pkg::SUM_W'(off);
  assign slot_idx    = slot_sum - dfm_pkg::SUM_W'(2);
  assign slot_ok     = (off != 5'd0) && (slot_sum >= dfm_pkg::SUM_W'(2)) &&
                       (slot_idx < dfm_pkg::SUM_W'(dfm_pkg::UNIVERSE_SIZE));
  assign wr_addr_nxt = slot_idx[dfm_pkg::SLOT_W-1:0];
  assign wr_en_nxt   = cmd.calc && slot_ok;

  // write stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) wr_en_r <= 1'b0;
    else wr_en_r <= wr_en_nxt;
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    wr_data_r <= wr_data_nxt;
  end

  // universe memory, one write and one registered read port
  assign rd_pos = pos_r - dfm_pkg::POS_W'(dfm_pkg::HEAD_LEN);

  always_ff @(posedge clk) begin
    if (cmd.clear) mem[clr_addr_r] <= 8'd0;
    else if (wr_en_r) mem[wr_addr_r] <= wr_data_r;
    if (cmd.rd) rd_data_r <= mem[rd_pos[dfm_pkg::SLOT_W-1:0]];
  end

  // frame position
  assign is_last = (pos_r == dfm_pkg::POS_W'(dfm_pkg::FRAME_LEN - 1));
  assign pos_nxt = is_last ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) pos_r <= '0;
    else if (cmd.emit) pos_r <= pos_nxt;
  end

  // outgoing frame word
  always_comb begin
    out_valid           = cmd.emit;
    out_data.frame_last = is_last;
    if (pos_r < dfm_pkg::POS_W'(dfm_pkg::HEAD_LEN))
      out_data.frame_byte = dfm_pkg::head_byte(pos_r);
    else if (is_last)
      out_data.frame_byte = dfm_pkg::EOM_BYTE;
    else
      out_data.frame_byte = rd_data_r;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dmx_fixture_mapper_framer.sv -----
// dmx_fixture_mapper_framer: top level joining the controller and the datapath
//
//  channel | ports                         | handshake
//  --------+-------------------------------+----------------------------------
//  input   | start, busy, in_data          | word taken when start & !busy
//  result  | out_valid, out_data           | one-cycle strobe, never stalled
//
// A set word runs through the accepting step, six channel steps through
// the one write port of the universe memory and a write-back step.
// A tick word is accepted, then a registered memory read, then the strobe.
// After reset a clearing pass zeroes the memory one slot a cycle, so busy
// stays high after reset until all UNIVERSE_SIZE (512) slots are cleared.
// The receiver cannot stall; each frame byte is shown for one cycle only.
`default_nettype none
module dmx_fixture_mapper_framer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire dfm_pkg::in_word_t   in_data,
  output logic                     out_valid,
  output dfm_pkg::out_word_t       out_data
);

  dfm_pkg::dp_cmd_t  cmd;
  dfm_pkg::dp_stat_t stat;

  // sequencing
  dfm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_data.cmd),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  // storage and arithmetic
  dfm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- verif/dmx_fixture_mapper_framer_tb.sv -----
// dmx_fixture_mapper_framer_tb: self-checking testbench for the dmx fixture mapper framer
`timescale 1ns / 1ps
module dmx_fixture_mapper_framer_tb;
  import dfm_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int RANDOM_N   = 1830;
  localparam int DRAIN_CYC  = 20;
  localparam int LIMIT_NS   = 2_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_data;

  // words waiting to be offered, frame bytes waiting to come out
  in_word_t  stim_q [$];
  out_word_t frame_q [$];

  // predicted universe and position within the outgoing frame
  logic [7:0] universe [UNIVERSE_SIZE];
  int         frame_pos = 0;
  int         fails = 0;

  // driver idling state
  int gap_left = 0;
  int calm_left = 0;

  dmx_fixture_mapper_framer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  // six 5-bit slot offsets packed from bit 0 upward
  function automatic logic [29:0] offsets(input logic [4:0] o_bri, input logic [4:0] o_red,
                                          input logic [4:0] o_grn, input logic [4:0] o_blu,
                                          input logic [4:0] o_wht, input logic [4:0] o_w2);
    return {o_w2, o_wht, o_blu, o_grn, o_red, o_bri};
  endfunction

  // word with every field random
  function automatic in_word_t noise_word();
    logic [95:0] r;
    in_word_t    w;
    r = {$urandom(), $urandom(), $urandom()};
    w = r[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w = noise_word();
    w.cmd = CMD_TICK;
    return w;
  endfunction

  function automatic in_word_t set_word(input logic [9:0] base, input logic [7:0] bri,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] wh,
                                        input logic [7:0] w2, input logic [29:0] map);
    in_word_t w;
    w.cmd          = CMD_SET;
    w.base_address = base;
    w.brightness   = bri;
    w.red          = r;
    w.green        = g;
    w.blue         = b;
    w.white        = wh;
    w.white_two    = w2;
    w.slot_map     = map;
    return w;
  endfunction

  // random fixture placement, mostly inside the universe
  function automatic in_word_t random_set();
    in_word_t   w;
    logic [4:0] o [6];
    int         pick;
    w = noise_word();
    w.cmd = CMD_SET;
    pick = $urandom_range(0, 9);
    if (pick < 7) w.base_address = 10'($urandom_range(1, UNIVERSE_SIZE));
    else if (pick == 7) w.base_address = 10'($urandom_range(UNIVERSE_SIZE - 40, UNIVERSE_SIZE + 2));
    else if (pick == 8) w.base_address = 10'($urandom_range(0, 2));
    if ($urandom_range(0, 4) != 0) begin
      foreach (o[k]) o[k] = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
      if ($urandom_range(0, 5) == 0) o[$urandom_range(1, 5)] = o[$urandom_range(0, 5)];
      w.slot_map = offsets(o[0], o[1], o[2], o[3], o[4], o[5]);
    end
    return w;
  endfunction

  // apply one accepted word to the predicted universe, or queue the frame byte a tick gives
  function automatic void take_word(input in_word_t w);
    logic [4:0] off [6];
    logic [7:0] val [6];
    out_word_t  fb;
    int         slot;
    if (w.cmd == CMD_SET) begin
      foreach (off[k]) off[k] = w.slot_map[5*k +: 5];
      val = '{w.brightness, w.red, w.green, w.blue, w.white, w.white_two};
      // colours are dimmed only when the fixture has no dimmer slot
      if (off[0] == 5'd0)
        for (int k = 1; k < 6; k++) val[k] = 8'((int'(val[k]) * int'(w.brightness)) / 255);
      // later channels overwrite earlier ones on a shared slot
      for (int k = 0; k < 6; k++) begin
        slot = int'(w.base_address) + int'(off[k]) - 2;
        if (off[k] != 5'd0 && slot >= 0 && slot < UNIVERSE_SIZE) universe[slot] = val[k];
      end
    end else begin
      if (frame_pos == 0) fb.frame_byte = SOM_BYTE;
      else if (frame_pos == 1) fb.frame_byte = LABEL_BYTE;
      else if (frame_pos == 2) fb.frame_byte = 8'(UNIVERSE_SIZE + 1);
      else if (frame_pos == 3) fb.frame_byte = 8'((UNIVERSE_SIZE + 1) >> 8);
      else if (frame_pos == 4) fb.frame_byte = START_CODE;
      else if (frame_pos < HEAD_LEN + UNIVERSE_SIZE) fb.frame_byte = universe[frame_pos - HEAD_LEN];
      else fb.frame_byte = EOM_BYTE;
      fb.frame_last = (frame_pos == FRAME_LEN - 1);
      frame_q.push_back(fb);
      frame_pos = (frame_pos == FRAME_LEN - 1) ? 0 : frame_pos + 1;
    end
  endfunction

  // driver: offer queued words, random hold-off between them with calm stretches
  always @(posedge clk) begin : drive
    logic     raise;
    in_word_t nxt;
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      raise = start;
      nxt   = in_data;
      if (start && !busy) begin
        take_word(in_data);
        raise = 1'b0;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 29) == 0) begin
          calm_left = $urandom_range(10, 40);
          gap_left  = 0;
        end else begin
          gap_left = $urandom_range(0, 10);
        end
      end
      if (!raise) begin
        if (gap_left > 0) gap_left--;
        else if (stim_q.size() > 0) begin
          nxt   = stim_q.pop_front();
          raise = 1'b1;
        end
      end
      start   <= raise;
      in_data <= nxt;
    end
  end

  // monitor: every strobed word against the oldest expected frame byte
  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst_n && out_valid) begin
      if (frame_q.size() == 0) begin
        $error("frame_byte: no word expected, got %h", out_data.frame_byte);
        fails++;
      end else begin
        want = frame_q.pop_front();
        if (out_data.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %h, got %h", want.frame_byte, out_data.frame_byte);
          fails++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last: expected %b, got %b", want.frame_last, out_data.frame_last);
          fails++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    foreach (universe[k]) universe[k] = 8'h00;

    // directed: extremes, dimming, shared slots, writes falling off either end
    stim_q.push_back(tick_word());
    stim_q.push_back(set_word(10'd1, 8'hFF, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01,
                              offsets(5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6)));
    stim_q.push_back(set_word(10'd512, 8'hFF, 8'h5A, 8'hA5, 8'h00, 8'h00, 8'h00,
                              offsets(5'd0, 5'd1, 5'd2, 5'd0, 5'd0, 5'd0)));
    stim_q.push_back(set_word(10'd0, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                              offsets(5'd0, 5'd1, 5'd2, 5'd0, 5'd0, 5'd0)));
    stim_q.push_back(set_word(10'd1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              offsets(5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31)));
    stim_q.push_back(set_word(10'd10, 8'h80, 8'hFF, 8'hFE, 8'h01, 8'h02, 8'h80,
                              offsets(5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5)));
    stim_q.push_back(set_word(10'd20, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
                              offsets(5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7)));
    stim_q.push_back(set_word(10'd20, 8'h80, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
                              offsets(5'd0, 5'd9, 5'd9, 5'd9, 5'd9, 5'd9)));
    stim_q.push_back(set_word(10'd30, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 30'd0));
    stim_q.push_back(set_word(10'd482, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A,
                              offsets(5'd31, 5'd30, 5'd29, 5'd1, 5'd31, 5'd0)));
    stim_q.push_back(set_word(10'd483, 8'hC3, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00,
                              offsets(5'd31, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0)));
    stim_q.push_back(set_word(10'd100, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              offsets(5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5)));
    stim_q.push_back(set_word(10'd101, 8'h01, 8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h01,
                              offsets(5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5)));
    stim_q.push_back(set_word(10'd200, 8'h00, 8'hAB, 8'hCD, 8'h00, 8'h00, 8'h00,
                              offsets(5'd1, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0)));
    repeat (4) stim_q.push_back(tick_word());

    // random: mostly ticks so several whole frames go out, sets landing mid-frame
    repeat (RANDOM_N) begin
      if ($urandom_range(0, 3) == 0) stim_q.push_back(random_set());
      else stim_q.push_back(tick_word());
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() > 0 || start) @(posedge clk);
    while (frame_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
